[rtl/tlfnv_pkg.sv]
`default_nettype none

package tlfnv_pkg;

  // Field and hash widths
  localparam int unsigned HashW = 64;
  localparam int unsigned ByteW = 8;

  // FNV-1a 64-bit constants
  localparam logic [HashW-1:0] FnvOffsetBasis = 64'hCBF2_9CE4_8422_2325;
  // Prime 0x100_0000_01B3 split as 2^40 plus a 9-bit low part
  localparam int unsigned      PrimeShift     = 40;
  localparam logic [8:0]       PrimeLow       = 9'h1B3;

  // Block close folds the eight bytes of the block hash
  localparam int unsigned      CloseFolds     = HashW / ByteW;
  localparam int unsigned      CntW           = 3;
  // First byte folds in the accept cycle, the rest in the close state
  localparam logic [CntW-1:0]  LastCnt        = CntW'(CloseFolds - 2);

  typedef enum logic [1:0] {
    MODE_TOP    = 2'd0,
    MODE_BLOCK  = 2'd1,
    MODE_CLOSE  = 2'd2,
    MODE_FINISH = 2'd3
  } mode_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_CLOSE = 1'b1
  } state_e;

endpackage

`default_nettype wire

[rtl/tlfnv_fold.sv]
`default_nettype none

module tlfnv_fold (
  input  wire logic [tlfnv_pkg::HashW-1:0] hash_i,
  input  wire logic [tlfnv_pkg::ByteW-1:0] byte_i,
  output logic      [tlfnv_pkg::HashW-1:0] hash_o
);

  logic [tlfnv_pkg::HashW-1:0] mixed;
  logic [tlfnv_pkg::HashW-1:0] low_prod;

  // Mix the byte into the low bits
  assign mixed = hash_i ^ {{(tlfnv_pkg::HashW - tlfnv_pkg::ByteW){1'b0}}, byte_i};

  // Multiply by the prime modulo 2^64: shifted copy plus a narrow constant product
  assign low_prod = mixed * {{(tlfnv_pkg::HashW - 9){1'b0}}, tlfnv_pkg::PrimeLow};
  assign hash_o   = (mixed << tlfnv_pkg::PrimeShift) + low_prod;

endmodule

`default_nettype wire

[rtl/two_level_fnv1a64_fingerprint.sv]
// Two-level FNV-1a 64-bit fingerprint engine.
// Input channel (in_valid_i / in_ready_o) carries a 2-bit mode and a byte.
//   Top-level byte and block byte items fold the byte into the combined or
//   the block hash in the cycle they are accepted: one item per cycle while idle.
//   A finish item loads the combined hash into the output register and
//   restarts both hashes.
//   A close item loads the block hash into the output register and folds
//   its lowest byte into the combined hash in the accept cycle, then folds
//   the other seven bytes through the single shared fold unit, one byte per
//   cycle, with in_ready_o low until the last of them is folded.
// Output channel (out_valid_o / out_ready_i) carries hash_value_o and
//   is_combined_o from a one-entry output register; a result appears the
//   cycle after its item is accepted.
// While a result waits, byte items are still taken; a close or finish item
//   waits until the output register drains or is being drained.
// Reset sets both hashes to the offset basis and empties the output register.
`default_nettype none

module two_level_fnv1a64_fingerprint (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [1:0]                        mode_i,
  input  wire logic [tlfnv_pkg::ByteW-1:0]       data_byte_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic      [tlfnv_pkg::HashW-1:0]       hash_value_o,
  output logic                                   is_combined_o
);

  localparam int unsigned RestW = tlfnv_pkg::HashW - tlfnv_pkg::ByteW;

  tlfnv_pkg::state_e               state_q, state_d;
  tlfnv_pkg::mode_e                mode;
  logic [tlfnv_pkg::CntW-1:0]      cnt_q, cnt_d;
  logic [RestW-1:0]                rest_q, rest_d;
  logic [tlfnv_pkg::HashW-1:0]     block_q, block_d;
  logic [tlfnv_pkg::HashW-1:0]     comb_q, comb_d;
  logic                            out_valid_q, out_valid_d;
  logic [tlfnv_pkg::HashW-1:0]     out_hash_q, out_hash_d;
  logic                            out_comb_q, out_comb_d;
  logic                            in_acc;
  logic [tlfnv_pkg::HashW-1:0]     fold_hash;
  logic [tlfnv_pkg::ByteW-1:0]     fold_byte;
  logic [tlfnv_pkg::HashW-1:0]     fold_out;

  // Shared fold unit
  tlfnv_fold u_fold (
    .hash_i (fold_hash),
    .byte_i (fold_byte),
    .hash_o (fold_out)
  );

  // Sequencer: next state, hash updates and output register load
  always_comb begin
    mode        = tlfnv_pkg::mode_e'(mode_i);
    in_ready_o  = (state_q == tlfnv_pkg::ST_IDLE) &&
                  ((mode == tlfnv_pkg::MODE_TOP) || (mode == tlfnv_pkg::MODE_BLOCK) ||
                   !out_valid_q || out_ready_i);
    in_acc      = in_valid_i && in_ready_o;
    state_d     = state_q;
    cnt_d       = cnt_q;
    rest_d      = rest_q;
    block_d     = block_q;
    comb_d      = comb_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_hash_d  = out_hash_q;
    out_comb_d  = out_comb_q;
    fold_hash   = comb_q;
    fold_byte   = rest_q[tlfnv_pkg::ByteW-1:0];
    unique case (state_q)
      tlfnv_pkg::ST_IDLE: begin
        unique case (mode)
          tlfnv_pkg::MODE_TOP: begin
            fold_byte = data_byte_i;
            if (in_acc) begin
              comb_d = fold_out;
            end
          end
          tlfnv_pkg::MODE_BLOCK: begin
            fold_hash = block_q;
            fold_byte = data_byte_i;
            if (in_acc) begin
              block_d = fold_out;
            end
          end
          tlfnv_pkg::MODE_CLOSE: begin
            // Fold the lowest block byte now, hold the rest for the close state
            fold_byte = block_q[tlfnv_pkg::ByteW-1:0];
            if (in_acc) begin
              comb_d      = fold_out;
              rest_d      = block_q[tlfnv_pkg::HashW-1:tlfnv_pkg::ByteW];
              block_d     = tlfnv_pkg::FnvOffsetBasis;
              cnt_d       = '0;
              state_d     = tlfnv_pkg::ST_CLOSE;
              out_valid_d = 1'b1;
              out_hash_d  = block_q;
              out_comb_d  = 1'b0;
            end
          end
          tlfnv_pkg::MODE_FINISH: begin
            if (in_acc) begin
              block_d     = tlfnv_pkg::FnvOffsetBasis;
              comb_d      = tlfnv_pkg::FnvOffsetBasis;
              out_valid_d = 1'b1;
              out_hash_d  = comb_q;
              out_comb_d  = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      tlfnv_pkg::ST_CLOSE: begin
        // Advance one block byte per cycle into the combined hash
        comb_d = fold_out;
        rest_d = {{tlfnv_pkg::ByteW{1'b0}}, rest_q[RestW-1:tlfnv_pkg::ByteW]};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == tlfnv_pkg::LastCnt) begin
          state_d = tlfnv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tlfnv_pkg::ST_IDLE;
      end
    endcase
  end

  // State and hash registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tlfnv_pkg::ST_IDLE;
      cnt_q       <= '0;
      block_q     <= tlfnv_pkg::FnvOffsetBasis;
      comb_q      <= tlfnv_pkg::FnvOffsetBasis;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      block_q     <= block_d;
      comb_q      <= comb_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rest_q     <= rest_d;
    out_hash_q <= out_hash_d;
    out_comb_q <= out_comb_d;
  end

  assign out_valid_o   = out_valid_q;
  assign hash_value_o  = out_hash_q;
  assign is_combined_o = out_comb_q;

`ifndef ASSERT_OFF
  a_close_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (mode == tlfnv_pkg::MODE_CLOSE) |=>
      out_valid_o && !is_combined_o && (state_q == tlfnv_pkg::ST_CLOSE) &&
      (block_q == tlfnv_pkg::FnvOffsetBasis))
    else $error("close item did not load block result or restart block hash");

  a_finish_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (mode == tlfnv_pkg::MODE_FINISH) |=>
      out_valid_o && is_combined_o && (comb_q == tlfnv_pkg::FnvOffsetBasis) &&
      (block_q == tlfnv_pkg::FnvOffsetBasis))
    else $error("finish item did not load combined result or restart hashes");

  a_close_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tlfnv_pkg::ST_CLOSE) |-> !in_ready_o && (cnt_q <= tlfnv_pkg::LastCnt))
    else $error("close sequence overran or took an item");

  a_close_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tlfnv_pkg::ST_CLOSE) && (cnt_q == tlfnv_pkg::LastCnt) |=>
      (state_q == tlfnv_pkg::ST_IDLE))
    else $error("close sequence did not end after the last byte");
`endif

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;

  localparam logic [63:0] FnvPrime   = 64'h0000_0100_0000_01B3;
  // FNV-1a 64 of the single byte 'a'
  localparam logic [63:0] FnvHashOfA = 64'hAF63_DC4C_8601_EC8C;
  localparam int          RandItems  = 1800;
  localparam int          StallLimit = 2000;
  localparam int          TailCycles = 16;

  typedef struct packed {
    logic [63:0] hash;
    logic        combined;
  } hash_rec_t;

  typedef struct packed {
    tlfnv_pkg::mode_e mode;
    logic [7:0]       data;
    logic             lit_ok;
    logic [63:0]      lit_hash;
  } stim_row_t;

  // Directed items; a literal hash is given where it is obvious
  localparam int DirCount = 22;
  localparam stim_row_t DirRows [0:DirCount-1] = '{
    '{tlfnv_pkg::MODE_FINISH, 8'h00, 1'b1, tlfnv_pkg::FnvOffsetBasis},  // empty finish
    '{tlfnv_pkg::MODE_CLOSE,  8'hFF, 1'b1, tlfnv_pkg::FnvOffsetBasis},  // empty close
    '{tlfnv_pkg::MODE_FINISH, 8'h00, 1'b0, 64'h0},
    '{tlfnv_pkg::MODE_BLOCK,  8'h61, 1'b0, 64'h0},
    '{tlfnv_pkg::MODE_CLOSE,  8'h00, 1'b1, FnvHashOfA},
    '{tlfnv_pkg::MODE_FINISH, 8'h3C, 1'b0, 64'h0},
    '{tlfnv_pkg::MODE_TOP,    8'h61, 1'b0, 64'h0},
    '{tlfnv_pkg::MODE_FINISH, 8'h00, 1'b1, FnvHashOfA},
    '{tlfnv_pkg::MODE_TOP,    8'h00, 1'b0, 64'h0},
    '{tlfnv_pkg::MODE_TOP,    8'hFF, 1'b0, 64'h0},
    '{tlfnv_pkg::MODE_BLOCK,  8'h00, 1'b0, 64'h0},
    '{tlfnv_pkg::MODE_BLOCK,  8'hFF, 1'b0, 64'h0},
    '{tlfnv_pkg::MODE_CLOSE,  8'hAA, 1'b0, 64'h0},
    '{tlfnv_pkg::MODE_BLOCK,  8'h55, 1'b0, 64'h0},
    '{tlfnv_pkg::MODE_FINISH, 8'h55, 1'b0, 64'h0},  // finish drops the open block
    '{tlfnv_pkg::MODE_CLOSE,  8'h00, 1'b1, tlfnv_pkg::FnvOffsetBasis},
    '{tlfnv_pkg::MODE_TOP,    8'h80, 1'b0, 64'h0},
    '{tlfnv_pkg::MODE_BLOCK,  8'h01, 1'b0, 64'h0},
    '{tlfnv_pkg::MODE_BLOCK,  8'hFE, 1'b0, 64'h0},
    '{tlfnv_pkg::MODE_CLOSE,  8'h7F, 1'b0, 64'h0},
    '{tlfnv_pkg::MODE_CLOSE,  8'h00, 1'b1, tlfnv_pkg::FnvOffsetBasis},  // back-to-back
    '{tlfnv_pkg::MODE_FINISH, 8'hFF, 1'b0, 64'h0}
  };

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  tlfnv_pkg::mode_e in_mode   = tlfnv_pkg::MODE_TOP;
  logic [7:0]       in_data   = 8'h00;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [63:0]      out_hash;
  logic             out_combined;

  // Predicted hash state
  logic [63:0] blk_hash = tlfnv_pkg::FnvOffsetBasis;
  logic [63:0] top_hash = tlfnv_pkg::FnvOffsetBasis;

  hash_rec_t   fingerprints_due [$];
  int          items_sent   = 0;
  int          mismatches   = 0;
  int          stall_cycles = 0;
  logic        idle_ok;

  // Both sides run without gaps through this stretch
  assign idle_ok = (items_sent < 900) || (items_sent >= 1200);

  two_level_fnv1a64_fingerprint dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .mode_i        (in_mode),
    .data_byte_i   (in_data),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .hash_value_o  (out_hash),
    .is_combined_o (out_combined)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
    return (h ^ {56'd0, b}) * FnvPrime;
  endfunction

  // Advance the predicted hashes; return 1 when the item yields a result
  function automatic bit fnv_predict(input tlfnv_pkg::mode_e m, input logic [7:0] d,
                                     output hash_rec_t rec);
    rec = '0;
    case (m)
      tlfnv_pkg::MODE_TOP: begin
        top_hash = fnv_fold(top_hash, d);
        return 1'b0;
      end
      tlfnv_pkg::MODE_BLOCK: begin
        blk_hash = fnv_fold(blk_hash, d);
        return 1'b0;
      end
      tlfnv_pkg::MODE_CLOSE: begin
        rec.hash     = blk_hash;
        rec.combined = 1'b0;
        // fold the block hash into the top level, low byte first
        for (int i = 0; i < 8; i++) top_hash = fnv_fold(top_hash, blk_hash[8*i +: 8]);
        blk_hash = tlfnv_pkg::FnvOffsetBasis;
        return 1'b1;
      end
      default: begin
        rec.hash     = top_hash;
        rec.combined = 1'b1;
        blk_hash     = tlfnv_pkg::FnvOffsetBasis;
        top_hash     = tlfnv_pkg::FnvOffsetBasis;
        return 1'b1;
      end
    endcase
  endfunction

  // Offer one item, wait for it to be taken, then record what it yields
  task automatic push_item(input tlfnv_pkg::mode_e m, input logic [7:0] d,
                           input bit lit_ok, input logic [63:0] lit_val);
    hash_rec_t rec;
    if (idle_ok && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= m;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (fnv_predict(m, d, rec)) begin
      if (lit_ok) rec.hash = lit_val;
      fingerprints_due = {fingerprints_due, rec};
    end
  endtask

  // One well-formed fingerprint: headers, closed blocks, maybe an open block, finish
  task automatic send_fingerprint();
    int n_blocks;
    int n_bytes;
    n_blocks = $urandom_range(0, 4);
    repeat ($urandom_range(0, 8))
      push_item(tlfnv_pkg::MODE_TOP, 8'($urandom_range(0, 255)), 1'b0, '0);
    for (int k = 0; k < n_blocks; k++) begin
      repeat ($urandom_range(0, 2))
        push_item(tlfnv_pkg::MODE_TOP, 8'($urandom_range(0, 255)), 1'b0, '0);
      n_bytes = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 16);
      repeat (n_bytes)
        push_item(tlfnv_pkg::MODE_BLOCK, 8'($urandom_range(0, 255)), 1'b0, '0);
      push_item(tlfnv_pkg::MODE_CLOSE, 8'($urandom_range(0, 255)), 1'b0, '0);
    end
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 5))
        push_item(tlfnv_pkg::MODE_BLOCK, 8'($urandom_range(0, 255)), 1'b0, '0);
    push_item(tlfnv_pkg::MODE_FINISH, 8'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, exp_v, act_v);
  endtask

  // Stimulus
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int r = 0; r < DirCount; r++)
      push_item(DirRows[r].mode, DirRows[r].data, DirRows[r].lit_ok, DirRows[r].lit_hash);
    while (items_sent < DirCount + RandItems) begin
      if ($urandom_range(0, 99) < 85) begin
        send_fingerprint();
      end else begin
        repeat ($urandom_range(1, 6))
          push_item(tlfnv_pkg::mode_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    1'b0, '0);
      end
    end
    in_valid <= 1'b0;
    // drain, then let a trailing close run out
    while (fingerprints_due.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (fingerprints_due.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off to back the block up
  initial begin : rx_side
    int hold_left;
    bit held_once;
    hold_left = 0;
    held_once = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (!held_once && items_sent >= 500) begin
        held_once = 1'b1;
        hold_left = 250;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !idle_ok || ($urandom_range(0, 99) >= 15);
      end
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin
    hash_rec_t exp_rec;
    if (rst_n && out_valid && out_ready) begin
      if (fingerprints_due.size() == 0) begin
        report_mismatch("unexpected result", 64'h0, out_hash);
      end else begin
        exp_rec = fingerprints_due.pop_front();
        if (out_hash !== exp_rec.hash)
          report_mismatch("hash_value", exp_rec.hash, out_hash);
        if (out_combined !== exp_rec.combined)
          report_mismatch("is_combined", {63'd0, exp_rec.combined}, {63'd0, out_combined});
      end
    end
  end

  // Watchdog: end the run when no item moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

endmodule
